// ===== rtl/lbps_pkg.sv =====
// Shared types and constants for the LED blink pattern sequencer.
`default_nettype none
package lbps_pkg;

  localparam int MODE_W     = 3;
  localparam int IDX_W      = 6;
  localparam int DUR_W      = 24;
  localparam int ENTRY_W    = DUR_W + 1;
  localparam int WD_W       = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 3'd0,
    MODE_LOAD    = 3'd1,
    MODE_START   = 3'd2,
    MODE_KICK    = 3'd3,
    MODE_RESTART = 3'd4,
    MODE_STOP    = 3'd5
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_TERM_LEVEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 1'd1;

  typedef struct packed {
    logic             running;
    logic             pin;
    logic [IDX_W-1:0] position;
    logic             len_zero;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/lbps_ram.sv =====
// Generic simple dual-port RAM (separate write and read addresses) with registered read.
`default_nettype none
module lbps_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [AW-1:0]            raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/lbps_seq.sv =====
// Script playback state, script memory and per-beat update.
`default_nettype none
module lbps_seq #(
  parameter int SCRIPT_DEPTH = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               item_fire,
  input  wire logic [lbps_pkg::MODE_W-1:0]        mode,
  input  wire logic [lbps_pkg::IDX_W-1:0]         entry_index,
  input  wire logic                               entry_flag,
  input  wire logic [lbps_pkg::DUR_W-1:0]         entry_duration,
  input  wire logic                               entry_last,
  input  wire logic                               cfg_we,
  input  wire logic [lbps_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [lbps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output lbps_pkg::stat_t                         stat
);
  import lbps_pkg::*;

  localparam int AW = (SCRIPT_DEPTH > 1) ? $clog2(SCRIPT_DEPTH) : 1;
  localparam int LW = $clog2(SCRIPT_DEPTH + 1);

  logic [LW-1:0]      len_r, len_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [DUR_W-1:0]   elapsed_r, elapsed_nxt;
  logic [WD_W-1:0]    wd_r, wd_nxt;
  logic               running_r, running_nxt;
  logic               term_r, term_nxt;
  logic [WD_W-1:0]    timeout_r, timeout_nxt;
  logic               byp_valid_r, byp_valid_nxt;
  logic [ENTRY_W-1:0] byp_data_r;

  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] cur_entry;
  logic [DUR_W-1:0]   limit;
  logic [DUR_W-1:0]   elapsed_inc;
  logic [WD_W-1:0]    wd_inc;
  logic [LW-1:0]      pos_plus;
  logic [AW-1:0]      pos_adv;
  logic               idx_ok;
  logic               mem_we;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  lbps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SCRIPT_DEPTH)
  ) u_script (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (pos_nxt),
    .rdata (rdata)
  );

  // read data always tracks the current position; a same-cycle load is forwarded
  assign cur_entry   = byp_valid_r ? byp_data_r : rdata;
  assign limit       = (cur_entry[DUR_W-1:0] == '0) ? DUR_W'(1) : cur_entry[DUR_W-1:0];
  assign elapsed_inc = elapsed_r + DUR_W'(1);
  assign wd_inc      = wd_r + WD_W'(1);
  assign pos_plus    = LW'(pos_r) + LW'(1);
  assign pos_adv     = (pos_plus == len_r) ? '0 : AW'(pos_plus);
  assign idx_ok      = int'(entry_index) < SCRIPT_DEPTH;
  assign wr_addr     = AW'(entry_index);
  assign wr_data     = {entry_flag, entry_duration};
  assign mem_we      = item_fire && (mode_t'(mode) == MODE_LOAD) && idx_ok;

  always_comb begin
    len_nxt     = len_r;
    pos_nxt     = pos_r;
    elapsed_nxt = elapsed_r;
    wd_nxt      = wd_r;
    running_nxt = running_r;
    if (item_fire) begin
      case (mode_t'(mode))
        MODE_TICK: begin
          if (running_r) begin
            if (elapsed_inc >= limit) begin
              elapsed_nxt = '0;
              if (len_r != '0) begin
                pos_nxt = pos_adv;
              end
            end else begin
              elapsed_nxt = elapsed_inc;
            end
            if (timeout_r != '0) begin
              wd_nxt = wd_inc;
              if (wd_inc >= timeout_r) begin
                running_nxt = 1'b0;
                len_nxt     = '0;
                pos_nxt     = '0;
                elapsed_nxt = '0;
                wd_nxt      = '0;
              end
            end
          end
        end
        MODE_LOAD: begin
          if (idx_ok && entry_last) begin
            len_nxt     = LW'(entry_index) + LW'(1);
            pos_nxt     = '0;
            elapsed_nxt = '0;
          end
        end
        MODE_START: begin
          if (!running_r && len_r != '0) begin
            running_nxt = 1'b1;
            elapsed_nxt = '0;
            wd_nxt      = '0;
          end
        end
        MODE_KICK: begin
          wd_nxt = '0;
        end
        MODE_RESTART: begin
          if (running_r) begin
            elapsed_nxt = '0;
          end
        end
        MODE_STOP: begin
          running_nxt = 1'b0;
          len_nxt     = '0;
          pos_nxt     = '0;
          elapsed_nxt = '0;
          wd_nxt      = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    term_nxt    = term_r;
    timeout_nxt = timeout_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_TERM_LEVEL: term_nxt    = cfg_wdata[0];
        CFG_TIMEOUT:    timeout_nxt = cfg_wdata[WD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign byp_valid_nxt = mem_we && (wr_addr == pos_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      pos_r       <= '0;
      elapsed_r   <= '0;
      wd_r        <= '0;
      running_r   <= 1'b0;
      term_r      <= 1'b0;
      timeout_r   <= '0;
      byp_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      elapsed_r   <= elapsed_nxt;
      wd_r        <= wd_nxt;
      running_r   <= running_nxt;
      term_r      <= term_nxt;
      timeout_r   <= timeout_nxt;
      byp_valid_r <= byp_valid_nxt;
    end
    byp_data_r <= wr_data;
  end

  assign stat.running  = running_r;
  assign stat.pin      = running_r ? ~cur_entry[DUR_W] : term_r;
  assign stat.position = IDX_W'(pos_r);
  assign stat.len_zero = (len_r == '0);

endmodule
`default_nettype wire

// ===== rtl/led_blink_pattern_sequencer_top.sv =====
// Top level of the LED blink pattern sequencer: handshakes and result stage.
// Throughput: one beat per cycle on the input, sustained with out_ready high.
// Flow: at the accepting edge pend_valid_r is set, and state and the script memory read
//   of the new position land; out_valid and the result register follow as pend_valid_r advances.
// Reset: synchronous active-low rst_n clears playback state and the valid flags; the result
//   data registers are not reset, and script memory contents are undefined until loaded.
`default_nettype none
module led_blink_pattern_sequencer_top #(
  parameter int SCRIPT_DEPTH = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [lbps_pkg::MODE_W-1:0]        in_mode,
  input  wire logic [lbps_pkg::IDX_W-1:0]         in_entry_index,
  input  wire logic                               in_entry_flag,
  input  wire logic [lbps_pkg::DUR_W-1:0]         in_entry_duration,
  input  wire logic                               in_entry_last,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_pin_level,
  output logic                                    out_playing,
  output logic      [lbps_pkg::IDX_W-1:0]         out_current_position,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lbps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lbps_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lbps_pkg::*;

  stat_t            stat;
  logic             in_fire;
  logic             pend_adv;
  logic             pend_valid_r, pend_valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_pin_r;
  logic             out_playing_r;
  logic [IDX_W-1:0] out_pos_r;

  assign cfg_ready = 1'b1;
  assign pend_adv  = !out_valid_r || out_ready;
  assign in_ready  = !pend_valid_r || pend_adv;
  assign in_fire   = in_valid && in_ready;

  lbps_seq #(
    .SCRIPT_DEPTH (SCRIPT_DEPTH)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_fire      (in_fire),
    .mode           (in_mode),
    .entry_index    (in_entry_index),
    .entry_flag     (in_entry_flag),
    .entry_duration (in_entry_duration),
    .entry_last     (in_entry_last),
    .cfg_we         (cfg_valid),
    .cfg_idx        (cfg_index),
    .cfg_wdata      (cfg_data),
    .stat           (stat)
  );

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (in_fire) begin
      pend_valid_nxt = 1'b1;
    end else if (pend_adv) begin
      pend_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (pend_valid_r && pend_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    if (pend_valid_r && pend_adv) begin
      out_pin_r     <= stat.pin;
      out_playing_r <= stat.running;
      out_pos_r     <= stat.position;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_pin_level        = out_pin_r;
  assign out_playing          = out_playing_r;
  assign out_current_position = out_pos_r;

  a_stopped_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.running |-> (stat.position == '0))
    else $error("stopped with nonzero position");

  a_running_has_script: assert property (@(posedge clk) disable iff (!rst_n)
    stat.running |-> !stat.len_zero)
    else $error("running with empty script");

  a_accept_fills_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pend_valid_r)
    else $error("accepted beat lost before result stage");

  a_pend_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while result stage is blocked");

endmodule
`default_nettype wire
